// ===== sv/clef_pkg.sv =====
// Package for the CLEFIA block cipher: types, codes, S-boxes and the F function.
package clef_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KINIT,
		ST_KGFN,
		ST_KSTORE,
		ST_DPRE,
		ST_DRUN,
		ST_OUT
	} state_t;

	localparam logic [2:0] REG_KEY0  = 3'd0;
	localparam logic [2:0] REG_KEY1  = 3'd1;
	localparam logic [2:0] REG_KEY2  = 3'd2;
	localparam logic [2:0] REG_KEY3  = 3'd3;
	localparam logic [2:0] REG_KSIZE = 3'd4;

	localparam logic [1:0] KS_128 = 2'd0;
	localparam logic [1:0] KS_192 = 2'd1;
	localparam logic [1:0] KS_256 = 2'd2;
	localparam logic [1:0] KS_BAD = 2'd3;

	localparam logic [15:0] SEED_128 = 16'h428a;
	localparam logic [15:0] SEED_192 = 16'h7137;
	localparam logic [15:0] SEED_256 = 16'hb5c0;
	localparam logic [15:0] CON_XA   = 16'hb7e1;
	localparam logic [15:0] CON_XB   = 16'h243f;
	localparam logic [15:0] CON_POLY = 16'ha830;
	localparam logic [7:0]  GF_RED   = 8'h0e;

	localparam int STORE_DEPTH = 56;

	localparam logic [7:0] SBOX0 [256] = '{
		8'h57,8'h49,8'hd1,8'hc6,8'h2f,8'h33,8'h74,8'hfb,8'h95,8'h6d,8'h82,8'hea,8'h0e,8'hb0,8'ha8,8'h1c,
		8'h28,8'hd0,8'h4b,8'h92,8'h5c,8'hee,8'h85,8'hb1,8'hc4,8'h0a,8'h76,8'h3d,8'h63,8'hf9,8'h17,8'haf,
		8'hbf,8'ha1,8'h19,8'h65,8'hf7,8'h7a,8'h32,8'h20,8'h06,8'hce,8'he4,8'h83,8'h9d,8'h5b,8'h4c,8'hd8,
		8'h42,8'h5d,8'h2e,8'he8,8'hd4,8'h9b,8'h0f,8'h13,8'h3c,8'h89,8'h67,8'hc0,8'h71,8'haa,8'hb6,8'hf5,
		8'ha4,8'hbe,8'hfd,8'h8c,8'h12,8'h00,8'h97,8'hda,8'h78,8'he1,8'hcf,8'h6b,8'h39,8'h43,8'h55,8'h26,
		8'h30,8'h98,8'hcc,8'hdd,8'heb,8'h54,8'hb3,8'h8f,8'h4e,8'h16,8'hfa,8'h22,8'ha5,8'h77,8'h09,8'h61,
		8'hd6,8'h2a,8'h53,8'h37,8'h45,8'hc1,8'h6c,8'hae,8'hef,8'h70,8'h08,8'h99,8'h8b,8'h1d,8'hf2,8'hb4,
		8'he9,8'hc7,8'h9f,8'h4a,8'h31,8'h25,8'hfe,8'h7c,8'hd3,8'ha2,8'hbd,8'h56,8'h14,8'h88,8'h60,8'h0b,
		8'hcd,8'he2,8'h34,8'h50,8'h9e,8'hdc,8'h11,8'h05,8'h2b,8'hb7,8'ha9,8'h48,8'hff,8'h66,8'h8a,8'h73,
		8'h03,8'h75,8'h86,8'hf1,8'h6a,8'ha7,8'h40,8'hc2,8'hb9,8'h2c,8'hdb,8'h1f,8'h58,8'h94,8'h3e,8'hed,
		8'hfc,8'h1b,8'ha0,8'h04,8'hb8,8'h8d,8'he6,8'h59,8'h62,8'h93,8'h35,8'h7e,8'hca,8'h21,8'hdf,8'h47,
		8'h15,8'hf3,8'hba,8'h7f,8'ha6,8'h69,8'hc8,8'h4d,8'h87,8'h3b,8'h9c,8'h01,8'he0,8'hde,8'h24,8'h52,
		8'h7b,8'h0c,8'h68,8'h1e,8'h80,8'hb2,8'h5a,8'he7,8'had,8'hd5,8'h23,8'hf4,8'h46,8'h3f,8'h91,8'hc9,
		8'h6e,8'h84,8'h72,8'hbb,8'h0d,8'h18,8'hd9,8'h96,8'hf0,8'h5f,8'h41,8'hac,8'h27,8'hc5,8'he3,8'h3a,
		8'h81,8'h6f,8'h07,8'ha3,8'h79,8'hf6,8'h2d,8'h38,8'h1a,8'h44,8'h5e,8'hb5,8'hd2,8'hec,8'hcb,8'h90,
		8'h9a,8'h36,8'he5,8'h29,8'hc3,8'h4f,8'hab,8'h64,8'h51,8'hf8,8'h10,8'hd7,8'hbc,8'h02,8'h7d,8'h8e
	};

	localparam logic [7:0] SBOX1 [256] = '{
		8'h6c,8'hda,8'hc3,8'he9,8'h4e,8'h9d,8'h0a,8'h3d,8'hb8,8'h36,8'hb4,8'h38,8'h13,8'h34,8'h0c,8'hd9,
		8'hbf,8'h74,8'h94,8'h8f,8'hb7,8'h9c,8'he5,8'hdc,8'h9e,8'h07,8'h49,8'h4f,8'h98,8'h2c,8'hb0,8'h93,
		8'h12,8'heb,8'hcd,8'hb3,8'h92,8'he7,8'h41,8'h60,8'he3,8'h21,8'h27,8'h3b,8'he6,8'h19,8'hd2,8'h0e,
		8'h91,8'h11,8'hc7,8'h3f,8'h2a,8'h8e,8'ha1,8'hbc,8'h2b,8'hc8,8'hc5,8'h0f,8'h5b,8'hf3,8'h87,8'h8b,
		8'hfb,8'hf5,8'hde,8'h20,8'hc6,8'ha7,8'h84,8'hce,8'hd8,8'h65,8'h51,8'hc9,8'ha4,8'hef,8'h43,8'h53,
		8'h25,8'h5d,8'h9b,8'h31,8'he8,8'h3e,8'h0d,8'hd7,8'h80,8'hff,8'h69,8'h8a,8'hba,8'h0b,8'h73,8'h5c,
		8'h6e,8'h54,8'h15,8'h62,8'hf6,8'h35,8'h30,8'h52,8'ha3,8'h16,8'hd3,8'h28,8'h32,8'hfa,8'haa,8'h5e,
		8'hcf,8'hea,8'hed,8'h78,8'h33,8'h58,8'h09,8'h7b,8'h63,8'hc0,8'hc1,8'h46,8'h1e,8'hdf,8'ha9,8'h99,
		8'h55,8'h04,8'hc4,8'h86,8'h39,8'h77,8'h82,8'hec,8'h40,8'h18,8'h90,8'h97,8'h59,8'hdd,8'h83,8'h1f,
		8'h9a,8'h37,8'h06,8'h24,8'h64,8'h7c,8'ha5,8'h56,8'h48,8'h08,8'h85,8'hd0,8'h61,8'h26,8'hca,8'h6f,
		8'h7e,8'h6a,8'hb6,8'h71,8'ha0,8'h70,8'h05,8'hd1,8'h45,8'h8c,8'h23,8'h1c,8'hf0,8'hee,8'h89,8'had,
		8'h7a,8'h4b,8'hc2,8'h2f,8'hdb,8'h5a,8'h4d,8'h76,8'h67,8'h17,8'h2d,8'hf4,8'hcb,8'hb1,8'h4a,8'ha8,
		8'hb5,8'h22,8'h47,8'h3a,8'hd5,8'h10,8'h4c,8'h72,8'hcc,8'h00,8'hf9,8'he0,8'hfd,8'he2,8'hfe,8'hae,
		8'hf8,8'h5f,8'hab,8'hf1,8'h1b,8'h42,8'h81,8'hd6,8'hbe,8'h44,8'h29,8'ha6,8'h57,8'hb9,8'haf,8'hf2,
		8'hd4,8'h75,8'h66,8'hbb,8'h68,8'h9f,8'h50,8'h02,8'h01,8'h3c,8'h7f,8'h8d,8'h1a,8'h88,8'hbd,8'hac,
		8'hf7,8'he4,8'h79,8'h96,8'ha2,8'hfc,8'h6d,8'hb2,8'h6b,8'h03,8'he1,8'h2e,8'h7d,8'h14,8'h95,8'h1d
	};

	localparam logic [3:0] MAT0 [4][4] = '{
		'{4'd1, 4'd2, 4'd4, 4'd6},
		'{4'd2, 4'd1, 4'd6, 4'd4},
		'{4'd4, 4'd6, 4'd1, 4'd2},
		'{4'd6, 4'd4, 4'd2, 4'd1}
	};

	localparam logic [3:0] MAT1 [4][4] = '{
		'{4'd1,  4'd8,  4'd2,  4'd10},
		'{4'd8,  4'd1,  4'd10, 4'd2},
		'{4'd2,  4'd10, 4'd1,  4'd8},
		'{4'd10, 4'd2,  4'd8,  4'd1}
	};

	function automatic logic [7:0] gf_dbl(input logic [7:0] x);
		logic [7:0] y;
		y = x[7] ? (x ^ GF_RED) : x;
		return {y[6:0], y[7]};
	endfunction

	function automatic logic [7:0] gf_mulc(input logic [7:0] x, input logic [3:0] c);
		logic [7:0] d1, d2, d3;
		d1 = gf_dbl(x);
		d2 = gf_dbl(d1);
		d3 = gf_dbl(d2);
		return (c[0] ? x : 8'h00) ^ (c[1] ? d1 : 8'h00) ^
			(c[2] ? d2 : 8'h00) ^ (c[3] ? d3 : 8'h00);
	endfunction

	// kind 0 is F0, kind 1 is F1
	function automatic logic [31:0] ffunc(input logic [31:0] x, input logic [31:0] k,
		input logic kind);
		logic [31:0] t;
		logic [7:0]  z [4];
		logic [7:0]  v;
		logic [31:0] y;
		t = x ^ k;
		for (int i = 0; i < 4; i++) begin
			if (((i % 2) == 1) ^ kind)
				z[i] = SBOX1[t[31 - 8 * i -: 8]];
			else
				z[i] = SBOX0[t[31 - 8 * i -: 8]];
		end
		y = 32'h0;
		for (int i = 0; i < 4; i++) begin
			v = 8'h00;
			for (int j = 0; j < 4; j++)
				v = v ^ gf_mulc(z[j], kind ? MAT1[i][j] : MAT0[i][j]);
			y[31 - 8 * i -: 8] = v;
		end
		return y;
	endfunction

	function automatic logic [127:0] double_swap(input logic [127:0] l);
		logic [63:0] hi, lo;
		hi = l[127:64];
		lo = l[63:0];
		return {hi[56:0], lo[6:0], hi[63:57], lo[63:7]};
	endfunction

endpackage

// ===== sv/clef_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module clef_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 56
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ===== sv/clefia_block_cipher.sv =====
// Top level of the CLEFIA block cipher: sequencer, shared F pair and key store.
// One block is processed at a time. After acceptance a block runs one Feistel round
// per cycle through the shared F0/F1 pair (R = 18, 22 or 26 rounds for 128, 192 or
// 256 bit keys), then hands the result to the output register and goes back to the
// ready state before a new block can be taken.
// A stalled result holds the sequencer until it is taken. The first block after
// any key register write first runs the key schedule through the same F pair: it
// loads the key, runs the GFN rounds and then writes one key word per cycle,
// whitening and round keys alike, into the key store.
module clefia_block_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [63:0] block_hi,
	input  logic [63:0] block_lo,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] result_hi,
	output logic [63:0] result_lo
);

	localparam int AW = $clog2(clef_pkg::STORE_DEPTH);

	clef_pkg::state_t state_q, state_d;

	logic [63:0] key_q [4];
	logic [1:0]  ksize_q;
	logic        keys_ready_q;
	logic [4:0]  round_total_q;
	logic        op_q;
	logic [31:0] w_q [4];
	logic [31:0] l_q [8];
	logic [15:0] t_q;
	logic [5:0]  cnt_q;
	logic [63:0] res_hi_q, res_lo_q;
	logic        out_valid_q;

	logic [31:0] k [8];
	logic        is128;
	logic [15:0] seed;
	logic [15:0] rot, swp, t_x, t_next;
	logic [31:0] con_a, con_b;
	logic [31:0] fx0, fk0, fx1, fk1, f0, f1;
	logic [31:0] rd_a, rd_b;
	logic [5:0]  last_idx, gfn_last, idx;
	logic [3:0]  ki;
	logic [1:0]  km;
	logic        right;
	logic [31:0] half_w, kx, rk_word, store_word;
	logic        in_rk;
	logic [5:0]  r_end, ns, pair;
	logic [AW-1:0] raddr_a, raddr_b;
	logic        store_we, out_load;
	logic [127:0] ds_lo, ds_hi;

	always_comb begin
		k[0] = key_q[0][63:32];
		k[1] = key_q[0][31:0];
		k[2] = key_q[1][63:32];
		k[3] = key_q[1][31:0];
		k[4] = key_q[2][63:32];
		k[5] = key_q[2][31:0];
		k[6] = key_q[3][63:32];
		k[7] = key_q[3][31:0];
		if (ksize_q == clef_pkg::KS_192) begin
			k[6] = ~key_q[0][63:32];
			k[7] = ~key_q[0][31:0];
		end
	end

	assign is128 = (ksize_q == clef_pkg::KS_128);
	assign seed = is128 ? clef_pkg::SEED_128 :
		((ksize_q == clef_pkg::KS_192) ? clef_pkg::SEED_192 : clef_pkg::SEED_256);

	// constant generator
	assign rot    = {t_q[14:0], t_q[15]};
	assign swp    = {t_q[7:0], t_q[15:8]};
	assign con_a  = {t_q ^ clef_pkg::CON_XA, ~rot};
	assign con_b  = {~t_q ^ clef_pkg::CON_XB, swp};
	assign t_x    = t_q[0] ? (t_q ^ clef_pkg::CON_POLY) : t_q;
	assign t_next = {t_x[0], t_x[15:1]};

	// shared F pair
	always_comb begin
		fx0 = w_q[0];
		fx1 = w_q[2];
		fk0 = rd_a;
		fk1 = rd_b;
		if (state_q == clef_pkg::ST_KGFN) begin
			fk0 = con_a;
			fk1 = con_b;
			if (!is128 && cnt_q[0]) begin
				fx0 = l_q[4];
				fx1 = l_q[6];
			end else begin
				fx0 = l_q[0];
				fx1 = l_q[2];
			end
		end
	end

	assign f0 = clef_pkg::ffunc(fx0, fk0, 1'b0);
	assign f1 = clef_pkg::ffunc(fx1, fk1, 1'b1);

	// key store word
	assign last_idx = is128 ? 6'd39 :
		((ksize_q == clef_pkg::KS_192) ? 6'd47 : 6'd55);
	assign gfn_last = is128 ? 6'd11 : 6'd19;
	assign idx      = cnt_q - 6'd2;
	assign ki       = idx[5:2];
	assign km       = idx[1:0];
	assign right    = !is128 && ki[1];
	assign half_w   = l_q[{right, km}];
	assign kx       = (is128 || right) ? k[{1'b0, km}] : k[{1'b1, km}];
	assign rk_word  = half_w ^ (km[0] ? con_b : con_a) ^ (ki[0] ? kx : 32'h0);
	assign in_rk    = (cnt_q >= 6'd2) && (cnt_q < last_idx - 6'd1);

	always_comb begin
		if (cnt_q < 6'd2)
			store_word = is128 ? k[{2'b00, cnt_q[0]}] :
				(k[{2'b00, cnt_q[0]}] ^ k[{2'b10, cnt_q[0]}]);
		else if (!in_rk)
			store_word = is128 ? k[{2'b01, cnt_q[0]}] :
				(k[{2'b01, cnt_q[0]}] ^ k[{2'b11, cnt_q[0]}]);
		else
			store_word = rk_word;
	end

	assign ds_lo = clef_pkg::double_swap({l_q[0], l_q[1], l_q[2], l_q[3]});
	assign ds_hi = clef_pkg::double_swap({l_q[4], l_q[5], l_q[6], l_q[7]});

	// data read addresses, one step ahead
	assign r_end = {1'b0, round_total_q} + 6'd1;
	assign ns    = (state_q != clef_pkg::ST_DRUN) ? 6'd0 :
		((cnt_q == r_end) ? cnt_q : cnt_q + 6'd1);
	assign pair  = op_q ? (r_end - ns) : ns;
	assign raddr_a = {pair[4:0], 1'b0};
	assign raddr_b = {pair[4:0], 1'b1};

	clef_ram #(
		.WIDTH(32),
		.DEPTH(clef_pkg::STORE_DEPTH)
	) u_store (
		.clk    (clk),
		.we     (store_we),
		.waddr  (cnt_q[AW-1:0]),
		.wdata  (store_word),
		.raddr_a(raddr_a),
		.rdata_a(rd_a),
		.raddr_b(raddr_b),
		.rdata_b(rd_b)
	);

	always_comb begin
		state_d  = state_q;
		store_we = 1'b0;
		out_load = 1'b0;
		in_ready = (state_q == clef_pkg::ST_IDLE);
		unique case (state_q)
			clef_pkg::ST_IDLE: begin
				if (in_valid)
					state_d = keys_ready_q ? clef_pkg::ST_DPRE : clef_pkg::ST_KINIT;
			end
			clef_pkg::ST_KINIT: state_d = clef_pkg::ST_KGFN;
			clef_pkg::ST_KGFN: begin
				if (cnt_q == gfn_last)
					state_d = clef_pkg::ST_KSTORE;
			end
			clef_pkg::ST_KSTORE: begin
				store_we = 1'b1;
				if (cnt_q == last_idx)
					state_d = clef_pkg::ST_DPRE;
			end
			clef_pkg::ST_DPRE: state_d = clef_pkg::ST_DRUN;
			clef_pkg::ST_DRUN: begin
				if (cnt_q == r_end)
					state_d = clef_pkg::ST_OUT;
			end
			clef_pkg::ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = clef_pkg::ST_IDLE;
				end
			end
			default: state_d = clef_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= clef_pkg::ST_IDLE;
			keys_ready_q  <= 1'b0;
			round_total_q <= 5'd18;
			out_valid_q   <= 1'b0;
			cnt_q         <= 6'd0;
			ksize_q       <= clef_pkg::KS_128;
			for (int i = 0; i < 4; i++)
				key_q[i] <= 64'h0;
		end else begin
			state_q <= state_d;
			if (state_q != state_d)
				cnt_q <= 6'd0;
			else
				cnt_q <= cnt_q + 6'd1;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (state_q == clef_pkg::ST_KSTORE && cnt_q == last_idx) begin
				keys_ready_q  <= 1'b1;
				round_total_q <= is128 ? 5'd18 :
					((ksize_q == clef_pkg::KS_192) ? 5'd22 : 5'd26);
			end
			if (cfg_we) begin
				unique case (cfg_index)
					clef_pkg::REG_KEY0: begin
						key_q[0] <= cfg_wdata;
						keys_ready_q <= 1'b0;
					end
					clef_pkg::REG_KEY1: begin
						key_q[1] <= cfg_wdata;
						keys_ready_q <= 1'b0;
					end
					clef_pkg::REG_KEY2: begin
						key_q[2] <= cfg_wdata;
						keys_ready_q <= 1'b0;
					end
					clef_pkg::REG_KEY3: begin
						key_q[3] <= cfg_wdata;
						keys_ready_q <= 1'b0;
					end
					clef_pkg::REG_KSIZE: begin
						ksize_q <= (cfg_wdata[1:0] == clef_pkg::KS_BAD) ?
							clef_pkg::KS_256 : cfg_wdata[1:0];
						keys_ready_q <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			clef_pkg::ST_IDLE: begin
				if (in_valid) begin
					op_q   <= op;
					w_q[0] <= block_hi[63:32];
					w_q[1] <= block_hi[31:0];
					w_q[2] <= block_lo[63:32];
					w_q[3] <= block_lo[31:0];
				end
			end
			clef_pkg::ST_KINIT: begin
				for (int i = 0; i < 8; i++)
					l_q[i] <= k[i];
				t_q <= seed;
			end
			clef_pkg::ST_KGFN: begin
				t_q <= t_next;
				if (is128) begin
					if (cnt_q == gfn_last) begin
						l_q[1] <= l_q[1] ^ f0;
						l_q[3] <= l_q[3] ^ f1;
					end else begin
						l_q[0] <= l_q[1] ^ f0;
						l_q[1] <= l_q[2];
						l_q[2] <= l_q[3] ^ f1;
						l_q[3] <= l_q[0];
					end
				end else if (!cnt_q[0]) begin
					l_q[1] <= l_q[1] ^ f0;
					l_q[3] <= l_q[3] ^ f1;
				end else if (cnt_q == gfn_last) begin
					l_q[5] <= l_q[5] ^ f0;
					l_q[7] <= l_q[7] ^ f1;
				end else begin
					l_q[0] <= l_q[1];
					l_q[1] <= l_q[2];
					l_q[2] <= l_q[3];
					l_q[3] <= l_q[4];
					l_q[4] <= l_q[5] ^ f0;
					l_q[5] <= l_q[6];
					l_q[6] <= l_q[7] ^ f1;
					l_q[7] <= l_q[0];
				end
			end
			clef_pkg::ST_KSTORE: begin
				if (in_rk && km[0])
					t_q <= t_next;
				if (in_rk && km == 2'd3) begin
					if (right) begin
						l_q[4] <= ds_hi[127:96];
						l_q[5] <= ds_hi[95:64];
						l_q[6] <= ds_hi[63:32];
						l_q[7] <= ds_hi[31:0];
					end else begin
						l_q[0] <= ds_lo[127:96];
						l_q[1] <= ds_lo[95:64];
						l_q[2] <= ds_lo[63:32];
						l_q[3] <= ds_lo[31:0];
					end
				end
			end
			clef_pkg::ST_DPRE: ;
			clef_pkg::ST_DRUN: begin
				if (cnt_q == 6'd0 || cnt_q == r_end) begin
					w_q[1] <= w_q[1] ^ rd_a;
					w_q[3] <= w_q[3] ^ rd_b;
				end else if (cnt_q == {1'b0, round_total_q}) begin
					w_q[1] <= w_q[1] ^ f0;
					w_q[3] <= w_q[3] ^ f1;
				end else if (!op_q) begin
					w_q[0] <= w_q[1] ^ f0;
					w_q[1] <= w_q[2];
					w_q[2] <= w_q[3] ^ f1;
					w_q[3] <= w_q[0];
				end else begin
					w_q[0] <= w_q[3] ^ f1;
					w_q[1] <= w_q[0];
					w_q[2] <= w_q[1] ^ f0;
					w_q[3] <= w_q[2];
				end
			end
			clef_pkg::ST_OUT: begin
				if (out_load) begin
					res_hi_q <= {w_q[0], w_q[1]};
					res_lo_q <= {w_q[2], w_q[3]};
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign result_hi = res_hi_q;
	assign result_lo = res_lo_q;

endmodule

// ===== sv/clef_checker.sv =====
// Port-level checker for the CLEFIA block cipher, bound to the top level.
module clef_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] result_hi,
	input logic [63:0] result_lo
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_hi) && $stable(result_lo))
		else $error("result changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("input taken while a block is in flight");

	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result presented while still busy");

endmodule

bind clefia_block_cipher clef_checker u_clef_checker (.*);
